### hdl/utf8_cluster_width_defines.svh
// ----------------------------------------------------------------------------
// utf8_cluster_width assertion macros
// Shared assertion forms for the UTF-8 cluster width decoder checkers.
// ----------------------------------------------------------------------------
`ifndef UTF8_CLUSTER_WIDTH_DEFINES_SVH
`define UTF8_CLUSTER_WIDTH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define U8CW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8cw assertion failed");

// Next-cycle implication, disabled during reset.
`define U8CW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8cw assertion failed");

`endif

### hdl/u8cw_pkg.sv
// ----------------------------------------------------------------------------
// u8cw_pkg
// Types, lead byte decoding and the display width table of the UTF-8
// cluster width decoder.
// ----------------------------------------------------------------------------
package u8cw_pkg;

   localparam int CodeW = 21;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [CodeW-1:0] code_point;
      logic [2:0]       byte_count;
      logic [1:0]       char_width;
      logic             starts_cluster;
      logic [1:0]       cluster_cells;
      logic             text_done;
   } rsp_type;

   // A decoded character before its width and cluster are known.
   typedef struct packed {
      logic [CodeW-1:0] code_point;
      logic [2:0]       byte_count;
      logic             text_done;
   } raw_type;

   // Up to three characters that one byte produces, in order from slot 0.
   typedef struct packed {
      logic [1:0]        cnt;
      raw_type [2:0]     slots;
   } batch_type;

   localparam int ZeroN = 14;
   localparam int WideN = 15;

   localparam logic [CodeW-1:0] ZERO_LO [ZeroN] = '{
      21'h00300, 21'h00483, 21'h00591, 21'h00610, 21'h0064b, 21'h006d6, 21'h00900,
      21'h0093a, 21'h00941, 21'h01ab0, 21'h01dc0, 21'h020d0, 21'h0fe00, 21'h0fe20};
   localparam logic [CodeW-1:0] ZERO_HI [ZeroN] = '{
      21'h0036f, 21'h00489, 21'h005bd, 21'h0061a, 21'h0065f, 21'h006dc, 21'h00903,
      21'h0093c, 21'h0094d, 21'h01aff, 21'h01dff, 21'h020f0, 21'h0fe0f, 21'h0fe2f};

   localparam logic [CodeW-1:0] WIDE_LO [WideN] = '{
      21'h01100, 21'h02e80, 21'h03041, 21'h03400, 21'h04e00, 21'h0a000, 21'h0ac00,
      21'h0f900, 21'h0fe30, 21'h0ff00, 21'h0ffe0, 21'h1f300, 21'h1f680, 21'h1f900,
      21'h20000};
   localparam logic [CodeW-1:0] WIDE_HI [WideN] = '{
      21'h0115f, 21'h0303e, 21'h033ff, 21'h04dbf, 21'h09fff, 21'h0a4cf, 21'h0d7a3,
      21'h0faff, 21'h0fe6f, 21'h0ff60, 21'h0ffe6, 21'h1f64f, 21'h1f6ff, 21'h1f9ff,
      21'h3fffd};

   // Sequence length that a lead byte opens.
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if (b >= 8'hf0) begin
         len = 3'd4;
      end else if (b >= 8'he0) begin
         len = 3'd3;
      end else if (b >= 8'hc0) begin
         len = 3'd2;
      end else begin
         len = 3'd1;
      end
      return len;
   endfunction

   // Masked value of a lead byte; a single byte keeps its whole value.
   function automatic logic [CodeW-1:0] lead_val(input logic [7:0] b);
      logic [7:0] v;
      if (b >= 8'hf0) begin
         v = b & 8'h07;
      end else if (b >= 8'he0) begin
         v = b & 8'h0f;
      end else if (b >= 8'hc0) begin
         v = b & 8'h1f;
      end else begin
         v = b;
      end
      return {{(CodeW-8){1'b0}}, v};
   endfunction

   function automatic logic [1:0] char_width(input logic [CodeW-1:0] cp);
      logic zero_hit;
      logic wide_hit;
      logic [1:0] w;
      zero_hit = (cp < 21'd32) || (cp >= 21'h7f && cp < 21'ha0);
      wide_hit = 1'b0;
      for (int k = 0; k < ZeroN; k++) begin
         if (cp >= ZERO_LO[k] && cp <= ZERO_HI[k]) begin
            zero_hit = 1'b1;
         end
      end
      for (int k = 0; k < WideN; k++) begin
         if (cp >= WIDE_LO[k] && cp <= WIDE_HI[k]) begin
            wide_hit = 1'b1;
         end
      end
      if (zero_hit) begin
         w = 2'd0;
      end else if (wide_hit) begin
         w = 2'd2;
      end else begin
         w = 2'd1;
      end
      return w;
   endfunction

endpackage

### hdl/u8cw_decode.sv
// ----------------------------------------------------------------------------
// u8cw_decode
// Sequence state of the decoder and the logic that turns one byte into
// zero to three decoded characters.
// ----------------------------------------------------------------------------
module u8cw_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  u8cw_pkg::req_type    item,
   output u8cw_pkg::batch_type  batch
);
   import u8cw_pkg::*;

   logic [CodeW-1:0] partial_ff, partial_in;
   logic [2:0]       exp_ff, exp_in;
   logic [1:0]       rc_ff, rc_in;
   logic [7:0]       held0_ff, held0_in;
   logic [7:0]       held1_ff, held1_in;

   logic [7:0]       b;
   logic             fin;
   logic [2:0]       b_len;
   logic [CodeW-1:0] b_val;
   logic [CodeW-1:0] h0_val;
   logic [2:0]       h1_len;
   logic [CodeW-1:0] h1_val;
   logic [CodeW-1:0] shifted;
   logic [CodeW-1:0] pair;
   logic             complete;

   assign b        = item.text_byte;
   assign fin      = item.final_byte;
   assign b_len    = lead_len(b);
   assign b_val    = lead_val(b);
   assign h0_val   = lead_val(held0_ff);
   assign h1_len   = lead_len(held1_ff);
   assign h1_val   = lead_val(held1_ff);
   assign shifted  = {partial_ff[CodeW-7:0], b[5:0]};
   assign pair     = {h1_val[CodeW-7:0], b[5:0]};
   assign complete = (exp_ff != 3'd0) &&
                     ((({1'b0, rc_ff} + 3'd1) >= exp_ff) || (rc_ff == 2'd3));

   always_comb begin
      batch      = '0;
      partial_in = partial_ff;
      exp_in     = exp_ff;
      rc_in      = rc_ff;
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      if (exp_ff == 3'd0) begin
         if (b_len == 3'd1 || fin) begin
            batch.cnt      = 2'd1;
            batch.slots[0] = '{code_point: b_val, byte_count: 3'd1, text_done: fin};
         end else begin
            held0_in   = b;
            partial_in = b_val;
            exp_in     = b_len;
            rc_in      = 2'd1;
         end
      end else if (complete) begin
         batch.cnt      = 2'd1;
         batch.slots[0] = '{code_point: shifted, byte_count: exp_ff, text_done: fin};
         partial_in     = '0;
         exp_in         = 3'd0;
         rc_in          = 2'd0;
      end else if (fin) begin
         // The text ended inside a sequence: the lead is cut, the rest re-decoded.
         partial_in     = '0;
         exp_in         = 3'd0;
         rc_in          = 2'd0;
         batch.slots[0] = '{code_point: h0_val, byte_count: 3'd1, text_done: 1'b0};
         if (rc_ff == 2'd1) begin
            batch.cnt      = 2'd2;
            batch.slots[1] = '{code_point: b_val, byte_count: 3'd1, text_done: 1'b1};
         end else if (h1_len == 3'd2) begin
            batch.cnt      = 2'd2;
            batch.slots[1] = '{code_point: pair, byte_count: 3'd2, text_done: 1'b1};
         end else begin
            batch.cnt      = 2'd3;
            batch.slots[1] = '{code_point: h1_val, byte_count: 3'd1, text_done: 1'b0};
            batch.slots[2] = '{code_point: b_val, byte_count: 3'd1, text_done: 1'b1};
         end
      end else begin
         partial_in = shifted;
         rc_in      = rc_ff + 2'd1;
         if (rc_ff == 2'd1) begin
            held1_in = b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         exp_ff     <= 3'd0;
         rc_ff      <= 2'd0;
      end else if (advance) begin
         partial_ff <= partial_in;
         exp_ff     <= exp_in;
         rc_ff      <= rc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

endmodule

### hdl/u8cw_emit.sv
// ----------------------------------------------------------------------------
// u8cw_emit
// Holds the characters of one byte, looks up each one's display width,
// tracks the open cluster and drives the result register.
// ----------------------------------------------------------------------------
module u8cw_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  u8cw_pkg::batch_type  batch,
   output logic                 ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output u8cw_pkg::rsp_type    rsp_data
);
   import u8cw_pkg::*;

   raw_type [2:0] slots_ff, slots_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          open_ff, open_in;
   logic          valid_ff, valid_in;
   rsp_type       data_ff, data_in;

   logic          advance;
   logic [1:0]    w;

   assign advance = (cnt_ff != 2'd0) && (!valid_ff || !rsp_stall);
   assign ready   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && advance);
   assign w       = char_width(slots_ff[0].code_point);

   always_comb begin
      slots_in = slots_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         slots_in = batch.slots;
         cnt_in   = batch.cnt;
      end else if (advance) begin
         slots_in[0] = slots_ff[1];
         slots_in[1] = slots_ff[2];
         cnt_in      = cnt_ff - 2'd1;
      end
   end

   always_comb begin
      data_in                = data_ff;
      valid_in               = valid_ff && rsp_stall;
      open_in                = open_ff;
      if (advance) begin
         valid_in            = 1'b1;
         data_in.code_point  = slots_ff[0].code_point;
         data_in.byte_count  = slots_ff[0].byte_count;
         data_in.char_width  = w;
         data_in.text_done   = slots_ff[0].text_done;
         if (w == 2'd0 && open_ff) begin
            data_in.starts_cluster = 1'b0;
            data_in.cluster_cells  = 2'd0;
         end else begin
            data_in.starts_cluster = 1'b1;
            data_in.cluster_cells  = (w == 2'd0) ? 2'd1 : w;
         end
         open_in = !slots_ff[0].text_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 2'd0;
         open_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         open_ff  <= open_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      data_ff  <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### hdl/utf8_cluster_width.sv
// ----------------------------------------------------------------------------
// utf8_cluster_width
// Streaming UTF-8 decoder that gives each character its display width and
// groups zero-width characters into the cluster before them.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while req_stall is low; the result
// port's one character per cycle while rsp_stall is low sets the throughput.
// Bytes pass the input register, characters the emit queue and the result
// register. A byte yields none, one or, if the text ends inside a sequence,
// two or three; these leave the three-entry queue one per cycle unless stalled,
// so such a final byte stalls the input until the last of them is leaving.
module utf8_cluster_width (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  u8cw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output u8cw_pkg::rsp_type rsp_data
);
   import u8cw_pkg::*;

   logic      in_valid_ff;
   req_type   in_data_ff;
   logic      consume;
   logic      batch_ready;
   batch_type batch;

   assign consume   = in_valid_ff && batch_ready;
   assign req_stall = in_valid_ff && !batch_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   u8cw_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (consume),
      .item    (in_data_ff),
      .batch   (batch)
   );

   u8cw_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (consume),
      .batch     (batch),
      .ready     (batch_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/u8cw_checker.sv
// ----------------------------------------------------------------------------
// u8cw_checker
// Port-level checks of the UTF-8 cluster width decoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "utf8_cluster_width_defines.svh"

module u8cw_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input u8cw_pkg::rsp_type rsp_data
);

   // A stalled transaction keeps its valid and its contents.
   `U8CW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   `U8CW_ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid, rsp_data.byte_count >= 3'd1 && rsp_data.byte_count <= 3'd4)

   // Only a zero-width character can join a cluster, and it adds no cells.
   `U8CW_ASSERT_IMPLY(a_join, clock, reset, rsp_valid && !rsp_data.starts_cluster, rsp_data.char_width == 2'd0 && rsp_data.cluster_cells == 2'd0)

   `U8CW_ASSERT_IMPLY(a_open, clock, reset, rsp_valid && rsp_data.starts_cluster, rsp_data.cluster_cells != 2'd0 && (rsp_data.cluster_cells == rsp_data.char_width || rsp_data.char_width == 2'd0))

endmodule

bind utf8_cluster_width u8cw_checker u_checker (.*);
